>>> hdl/usdl_pkg.sv
// ---------------------------------------------------------------------------
// usdl_pkg
// Shared types, codes and constants of the USDL transfer frame parser.
// ---------------------------------------------------------------------------
`default_nettype none

package usdl_pkg;

  // Front-to-back queue depth default
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned POS_W  = 17;
  localparam int unsigned CFG_W  = 17;
  localparam int unsigned CIDX_W = 3;

  localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

  // Header geometry
  localparam logic [3:0] HDR_TRUNC_LEN = 4'd4;
  localparam logic [3:0] HDR_BASE_LEN  = 4'd7;
  localparam logic [2:0] OCF_LEN       = 3'd4;
  localparam logic [2:0] RULES_FHP_MAX = 3'd2;

  // Byte roles
  localparam logic [2:0] ROLE_HDR  = 3'd0;
  localparam logic [2:0] ROLE_INS  = 3'd1;
  localparam logic [2:0] ROLE_DFH  = 3'd2;
  localparam logic [2:0] ROLE_PAY  = 3'd3;
  localparam logic [2:0] ROLE_OCF  = 3'd4;
  localparam logic [2:0] ROLE_FEC  = 3'd5;
  localparam logic [2:0] ROLE_DISC = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_VERSION = 2'd1;
  localparam logic [1:0] ST_LENGTH  = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_EXP_VERSION = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_FRAME_LEN   = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_VAR_LEN     = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_FEC_PRESENT = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FEC_BYTES   = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_INS_BYTES   = 3'd5;

  // Field capture actions carried from front to back
  typedef enum logic [3:0] {
    OP_NONE,
    OP_HDR0,
    OP_HDR1,
    OP_HDR2,
    OP_HDR3,
    OP_HDR4,
    OP_HDR5,
    OP_HDR6,
    OP_COUNT,
    OP_DFH0,
    OP_DFH1,
    OP_DFH2
  } usdl_op_t;

  typedef struct packed {
    logic [3:0]       expected_version;
    logic [POS_W-1:0] frame_length;
    logic             variable_length;
    logic             fec_present;
    logic [7:0]       fec_bytes;
    logic [7:0]       insert_bytes;
  } usdl_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } usdl_in_t;

  typedef struct packed {
    logic [2:0]  role;
    logic [7:0]  byte_out;
    logic [1:0]  status;
    logic [15:0] spacecraft_id;
    logic [5:0]  channel_id;
    logic [3:0]  map_number;
    logic [4:0]  header_flags;
    logic [55:0] frame_count;
    logic [2:0]  construction_rules;
    logic [4:0]  protocol_id;
    logic [15:0] first_header_pointer;
    logic        last_of_frame;
  } usdl_out_t;

  // Queue entry: one classified byte
  typedef struct packed {
    logic [2:0] role;
    logic [7:0] data;
    logic [1:0] status;
    usdl_op_t   op;
    logic       clr;
    logic       last;
  } usdl_qent_t;

  typedef struct packed {
    logic full;
    logic empty;
  } usdl_qstat_t;

endpackage

`default_nettype wire

>>> hdl/usdl_cfg.sv
// ---------------------------------------------------------------------------
// usdl_cfg
// Configuration register file, write-only, one register per used index (0 to 5).
// ---------------------------------------------------------------------------
`default_nettype none

module usdl_cfg
  import usdl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  output usdl_cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= 4'd12;
      cfg.frame_length     <= 17'd256;
      cfg.variable_length  <= 1'b0;
      cfg.fec_present      <= 1'b0;
      cfg.fec_bytes        <= 8'd0;
      cfg.insert_bytes     <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EXP_VERSION: cfg.expected_version <= cfg_data[3:0];
        CFG_FRAME_LEN:   cfg.frame_length     <= cfg_data;
        CFG_VAR_LEN:     cfg.variable_length  <= cfg_data[0];
        CFG_FEC_PRESENT: cfg.fec_present      <= cfg_data[0];
        CFG_FEC_BYTES:   cfg.fec_bytes        <= cfg_data[7:0];
        CFG_INS_BYTES:   cfg.insert_bytes     <= cfg_data[7:0];
        default: ;  // unused indexes ignored
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/usdl_front.sv
// ---------------------------------------------------------------------------
// usdl_front
// Byte classifier: tracks position, frame end and error, picks the role and
// the capture action of each byte and pushes it to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module usdl_front
  import usdl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire usdl_cfg_t  cfg,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire usdl_in_t   in_data,
  input  wire usdl_qstat_t q_stat,
  output logic       q_push,
  output usdl_qent_t q_wdata
);

  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] fend, fend_next;
  logic [1:0]       err, err_next;
  logic             trunc, trunc_next;
  logic             ocf, ocf_next;
  logic [2:0]       clen, clen_next;
  logic [2:0]       rules, rules_next;
  logic [7:0]       len_hi, len_hi_next;

  logic [POS_W-1:0] e_pos;
  logic [3:0]       hdr_len;
  logic [8:0]       ins_end;
  logic [7:0]       fec_len;
  logic [2:0]       ocf_len;
  logic [POS_W:0]   pos_x, fend_x, fec_sum, ocf_sum;
  logic [POS_W-1:0] len_field;
  logic             len_bad;
  logic [7:0]       b;
  logic [2:0]       role;
  usdl_op_t         op;

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && in_ready;
  assign b        = in_data.data_byte;

  always_comb begin
    // frame start restarts all per-frame tracking
    e_pos       = in_data.frame_start ? '0 : pos;
    fend_next   = in_data.frame_start ? cfg.frame_length : fend;
    err_next    = in_data.frame_start ? ST_OK : err;
    trunc_next  = in_data.frame_start ? 1'b0 : trunc;
    ocf_next    = in_data.frame_start ? 1'b0 : ocf;
    clen_next   = in_data.frame_start ? 3'd0 : clen;
    rules_next  = in_data.frame_start ? 3'd0 : rules;
    len_hi_next = in_data.frame_start ? 8'd0 : len_hi;

    hdr_len = trunc_next ? HDR_TRUNC_LEN : HDR_BASE_LEN + {1'b0, clen_next};
    ins_end = {5'd0, hdr_len} + {1'b0, cfg.insert_bytes};
    fec_len = cfg.fec_present ? cfg.fec_bytes : 8'd0;
    ocf_len = ocf_next ? OCF_LEN : 3'd0;
    pos_x   = {1'b0, e_pos};
    fend_x  = {1'b0, fend_next};
    fec_sum = pos_x + {10'd0, fec_len};
    ocf_sum = fec_sum + {15'd0, ocf_len};

    len_field = {1'b0, len_hi_next, b} + 17'd1;
    len_bad   = cfg.variable_length ? (len_field > cfg.frame_length)
                                    : (len_field != cfg.frame_length);

    role = ROLE_DISC;
    op   = OP_NONE;

    if (e_pos < fend_next && err_next == ST_OK) begin
      if (e_pos < {13'd0, HDR_TRUNC_LEN} ||
          (!trunc_next && e_pos < {13'd0, hdr_len})) begin
        role = ROLE_HDR;
        if (e_pos == 17'd0) begin
          op = OP_HDR0;
          if (b[7:4] != cfg.expected_version) err_next = ST_VERSION;
        end else if (e_pos == 17'd1) begin
          op = OP_HDR1;
        end else if (e_pos == 17'd2) begin
          op = OP_HDR2;
        end else if (e_pos == 17'd3) begin
          op         = OP_HDR3;
          trunc_next = b[0];
        end else if (e_pos == 17'd4) begin
          op          = OP_HDR4;
          len_hi_next = b;
        end else if (e_pos == 17'd5) begin
          op          = OP_HDR5;
          len_hi_next = 8'd0;
          if (len_bad) err_next = ST_LENGTH;
          else         fend_next = len_field;
        end else if (e_pos == 17'd6) begin
          op        = OP_HDR6;
          ocf_next  = b[3];
          clen_next = b[2:0];
        end else begin
          op = OP_COUNT;
        end
      end else if (e_pos < {8'd0, ins_end}) begin
        role = ROLE_INS;
      end else if (e_pos == {8'd0, ins_end}) begin
        role       = ROLE_DFH;
        op         = OP_DFH0;
        rules_next = b[7:5];
      end else if (rules_next <= RULES_FHP_MAX &&
                   pos_x <= {9'd0, ins_end} + 18'd2) begin
        role = ROLE_DFH;
        op   = (pos_x == {9'd0, ins_end} + 18'd1) ? OP_DFH1 : OP_DFH2;
      end else if (fec_sum >= fend_x) begin
        role = ROLE_FEC;
      end else if (ocf_sum >= {1'b0, fend_next}) begin
        role = ROLE_OCF;
      end else begin
        role = ROLE_PAY;
      end
    end

    pos_next = (e_pos < POS_MAX) ? e_pos + 17'd1 : e_pos;

    q_wdata.role   = role;
    q_wdata.data   = b;
    q_wdata.status = err_next;
    q_wdata.op     = op;
    q_wdata.clr    = in_data.frame_start;
    q_wdata.last   = (fend_next != '0) && (pos_x + 18'd1 == {1'b0, fend_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      fend   <= '0;
      err    <= ST_OK;
      trunc  <= 1'b0;
      ocf    <= 1'b0;
      clen   <= 3'd0;
      rules  <= 3'd0;
      len_hi <= 8'd0;
    end else if (q_push) begin
      pos    <= pos_next;
      fend   <= fend_next;
      err    <= err_next;
      trunc  <= trunc_next;
      ocf    <= ocf_next;
      clen   <= clen_next;
      rules  <= rules_next;
      len_hi <= len_hi_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/usdl_queue.sv
// ---------------------------------------------------------------------------
// usdl_queue
// Small FIFO of classified bytes between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module usdl_queue
  import usdl_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire usdl_qent_t wdata,
  input  wire logic  pop,
  output usdl_qent_t rdata,
  output usdl_qstat_t stat
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  usdl_qent_t    mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign rdata      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/usdl_back.sv
// ---------------------------------------------------------------------------
// usdl_back
// Field capture and output register: applies each byte's capture action
// to the header fields and presents the tagged result.
// ---------------------------------------------------------------------------
`default_nettype none

module usdl_back
  import usdl_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire usdl_qstat_t q_stat,
  input  wire usdl_qent_t  q_rdata,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output usdl_out_t   out_data
);

  logic [15:0] scid, scid_next;
  logic [5:0]  vcid, vcid_next;
  logic [3:0]  map, map_next;
  logic [4:0]  flags, flags_next;
  logic [55:0] count, count_next;
  logic [2:0]  rules, rules_next;
  logic [4:0]  upid, upid_next;
  logic [15:0] fhp, fhp_next;
  logic [7:0]  b;

  assign q_pop = !q_stat.empty && (!out_valid || out_ready);
  assign b     = q_rdata.data;

  always_comb begin
    scid_next  = q_rdata.clr ? 16'd0 : scid;
    vcid_next  = q_rdata.clr ? 6'd0  : vcid;
    map_next   = q_rdata.clr ? 4'd0  : map;
    flags_next = q_rdata.clr ? 5'd0  : flags;
    count_next = q_rdata.clr ? 56'd0 : count;
    rules_next = q_rdata.clr ? 3'd0  : rules;
    upid_next  = q_rdata.clr ? 5'd0  : upid;
    fhp_next   = q_rdata.clr ? 16'd0 : fhp;

    unique case (q_rdata.op)
      OP_HDR0: scid_next = {b[3:0], 12'd0};
      OP_HDR1: scid_next[11:4] = scid_next[11:4] | b;
      OP_HDR2: begin
        scid_next[3:0] = scid_next[3:0] | b[7:4];
        flags_next[0]  = flags_next[0] | b[3];
        vcid_next[5:3] = vcid_next[5:3] | b[2:0];
      end
      OP_HDR3: begin
        vcid_next[2:0] = vcid_next[2:0] | b[7:5];
        map_next       = map_next | b[4:1];
        flags_next[1]  = flags_next[1] | b[0];
      end
      OP_HDR4: count_next = {48'd0, b};
      OP_HDR5: count_next = 56'd0;  // length high byte no longer shown
      OP_HDR6: begin
        flags_next[2] = flags_next[2] | b[7];
        flags_next[3] = flags_next[3] | b[6];
        flags_next[4] = flags_next[4] | b[3];
      end
      OP_COUNT: count_next = {count_next[47:0], b};
      OP_DFH0: begin
        rules_next = b[7:5];
        upid_next  = b[4:0];
        fhp_next   = 16'd0;
      end
      OP_DFH1: fhp_next[15:8] = fhp_next[15:8] | b;
      OP_DFH2: fhp_next[7:0]  = fhp_next[7:0] | b;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scid  <= '0;
      vcid  <= '0;
      map   <= '0;
      flags <= '0;
      count <= '0;
      rules <= '0;
      upid  <= '0;
      fhp   <= '0;
    end else if (q_pop) begin
      scid  <= scid_next;
      vcid  <= vcid_next;
      map   <= map_next;
      flags <= flags_next;
      count <= count_next;
      rules <= rules_next;
      upid  <= upid_next;
      fhp   <= fhp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data.role                 <= q_rdata.role;
      out_data.byte_out             <= b;
      out_data.status               <= q_rdata.status;
      out_data.spacecraft_id        <= scid_next;
      out_data.channel_id           <= vcid_next;
      out_data.map_number           <= map_next;
      out_data.header_flags         <= flags_next;
      out_data.frame_count          <= count_next;
      out_data.construction_rules   <= rules_next;
      out_data.protocol_id          <= upid_next;
      out_data.first_header_pointer <= fhp_next;
      out_data.last_of_frame        <= q_rdata.last;
    end
  end

endmodule

`default_nettype wire

>>> hdl/usdl_frame_parser.sv
// Path: a transferred byte is written into the queue, then into the output
// register. Throughput: one byte per cycle while the queue is not full;
// position compares and field shifts are combinational, and the queue absorbs output stalls of up to QUEUE_DEPTH bytes.
// Reset (rst, synchronous): config registers take their defaults, position
// and frame end clear, so bytes before the first frame start are discarded.
// ---------------------------------------------------------------------------
// usdl_frame_parser
// USDL transfer frame parser: tags each byte with its role in the frame and
// shows the header fields captured so far.
// ---------------------------------------------------------------------------
`default_nettype none

module usdl_frame_parser
  import usdl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration writes
  input  wire logic              cfg_wr_en,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data,
  // byte input
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire usdl_in_t          in_data,
  // tagged result
  output logic                   out_valid,
  input  wire logic              out_ready,
  output usdl_out_t              out_data
);

  usdl_cfg_t   cfg;
  usdl_qstat_t q_stat;
  usdl_qent_t  q_wdata, q_rdata;
  logic        q_push, q_pop;

  usdl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Front: classifies each byte transfer and keeps the frame tracking
  // state (position, frame end, error) so the next byte can follow at once.
  usdl_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  // Queue decouples input transfers from output stalls.
  usdl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: captures header fields and drives the output register.
  usdl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // back never reads an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // a transferred byte is in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    q_push |=> !q_stat.empty)
    else $error("pushed byte lost");

  // an error status only comes with the error byte or discarded bytes
  a_err_role: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |->
      (out_data.role == ROLE_HDR || out_data.role == ROLE_DISC))
    else $error("error status on a live byte");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

>>> tb/usdl_frame_parser_tb.sv
// ---------------------------------------------------------------------------
// usdl_frame_parser_tb
// Self-checking bench for the USDL frame parser. Frames are built from
// random content around a forced version, length and truncation bit, in
// well-formed and broken shapes, and sent over phases of different register
// settings. A local model tags every transferred byte. The monitor compares
// each result transfer field by field with the oldest pending tag.
// ---------------------------------------------------------------------------
module usdl_frame_parser_tb;
  import usdl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_PHASES     = 8;
  localparam int unsigned PHASE_BYTES  = 50;    // stimulus budget per phase
  localparam int unsigned STALL_PHASE  = 4;     // phase with the long output hold
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned SEND_MAX     = 240;   // longest byte run sent for one frame
  localparam int unsigned DRAIN_CYCLES = 8;     // > pipeline plus output queue
  localparam int unsigned MAX_PRINTED  = 60;
  localparam int unsigned TIMEOUT_NS   = 5_000_000;

  // Unused register slots; writes to them must leave the block unchanged
  localparam logic [CIDX_W-1:0] CFG_SPARE    = 3'd6;
  localparam logic [CIDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef enum {
    FRM_GOOD,         // complete frame, correct version and length
    FRM_TRUNC,        // truncated header, configured length applies
    FRM_BAD_VERSION,
    FRM_BAD_LENGTH,
    FRM_CUT,          // next frame start arrives before the end
    FRM_OVERRUN,      // extra bytes after the frame end
    FRM_NOISE         // loose bytes with random frame starts
  } frame_kind_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  usdl_in_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  usdl_out_t         out_data;

  usdl_frame_parser DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting for the driver, and tags waiting for the monitor
  usdl_in_t  bytes_to_send[$];
  usdl_out_t tags_due[$];

  int unsigned tx_idle_pct = 28;
  int unsigned rx_idle_pct = 28;
  int unsigned hold_asked  = 0;     // bumped by stimulus, served by the monitor
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned error_count  = 0;
  int unsigned results_seen = 0;

  // -------------------------------------------------------------------------
  // Parser model: register copy plus per-frame state
  // -------------------------------------------------------------------------
  usdl_cfg_t   cfg_m;
  logic [16:0] fr_pos;       // position of the next byte, saturating
  logic [16:0] fr_end;       // frame length in bytes, zero while idle
  logic [26:0] fr_ids;       // scid[25:10] vcid[9:4] map[3:0]
  logic [4:0]  fr_flags;
  logic [2:0]  fr_cnt_len;
  logic [55:0] fr_count;     // also parks the high length byte for one byte
  logic [23:0] fr_dfh;       // rules[23:21] upid[20:16] pointer[15:0]
  logic [1:0]  fr_status;

  task automatic clear_frame_state();
    fr_pos     = '0;
    fr_end     = '0;
    fr_ids     = '0;
    fr_flags   = '0;
    fr_cnt_len = '0;
    fr_count   = '0;
    fr_dfh     = '0;
    fr_status  = ST_OK;
  endtask

  // Tag one byte and advance the frame state
  task automatic tag_byte(input usdl_in_t item, output usdl_out_t res);
    logic [7:0]  b;
    logic [2:0]  role;
    logic        trunc;
    int unsigned p, hdr_len, ins_end, fec_len, ocf_len, flen;
    b    = item.data_byte;
    role = ROLE_DISC;
    if (item.frame_start) begin
      clear_frame_state();
      fr_end = cfg_m.frame_length;
    end
    p = fr_pos;

    // Anything past the frame end, or after an error, stays discarded
    if (p < fr_end && fr_status == ST_OK) begin
      trunc   = fr_flags[1];
      hdr_len = trunc ? HDR_TRUNC_LEN : HDR_BASE_LEN + fr_cnt_len;
      ins_end = hdr_len + cfg_m.insert_bytes;
      fec_len = cfg_m.fec_present ? cfg_m.fec_bytes : 0;
      ocf_len = fr_flags[4] ? OCF_LEN : 0;

      if (p < HDR_TRUNC_LEN || (!trunc && p < hdr_len)) begin
        // The byte that reveals an error keeps the header role
        role = ROLE_HDR;
        if (p == 0) begin
          if (b[7:4] != cfg_m.expected_version) fr_status = ST_VERSION;
          fr_ids = 27'(b[3:0]) << 22;
        end else if (p == 1) begin
          fr_ids |= 27'(b) << 14;
        end else if (p == 2) begin
          fr_ids      |= 27'(b[7:4]) << 10;
          fr_flags[0] |= b[3];
          fr_ids      |= 27'(b[2:0]) << 7;
        end else if (p == 3) begin
          fr_ids      |= 27'(b[7:5]) << 4;
          fr_ids      |= 27'(b[4:1]);
          fr_flags[1] |= b[0];
        end else if (p == 4) begin
          fr_count = 56'(b);
        end else if (p == 5) begin
          // Length field holds the frame length minus one
          flen     = ((fr_count[31:0] << 8) | b) + 1;
          fr_count = '0;
          if (cfg_m.variable_length ? (flen > cfg_m.frame_length)
                                    : (flen != cfg_m.frame_length))
            fr_status = ST_LENGTH;
          else
            fr_end = flen[16:0];
        end else if (p == 6) begin
          fr_flags[2] |= b[7];
          fr_flags[3] |= b[6];
          fr_flags[4] |= b[3];
          fr_cnt_len   = b[2:0];
        end else begin
          fr_count = {fr_count[47:0], b};
        end
      end else if (p < ins_end) begin
        role = ROLE_INS;
      end else if (p == ins_end) begin
        role   = ROLE_DFH;
        fr_dfh = {b[7:5], b[4:0], 16'h0000};
      end else if (fr_dfh[23:21] <= RULES_FHP_MAX && p <= ins_end + 2) begin
        // Pointer present, high byte first
        role = ROLE_DFH;
        if (p == ins_end + 1) fr_dfh[15:8] |= b;
        else                  fr_dfh[7:0]  |= b;
      end else if (p + fec_len >= fr_end) begin
        role = ROLE_FEC;
      end else if (p + fec_len + ocf_len >= fr_end) begin
        role = ROLE_OCF;
      end else begin
        role = ROLE_PAY;
      end
    end

    res.role                 = role;
    res.byte_out             = b;
    res.status               = fr_status;
    res.spacecraft_id        = fr_ids[25:10];
    res.channel_id           = fr_ids[9:4];
    res.map_number           = fr_ids[3:0];
    res.header_flags         = fr_flags;
    res.frame_count          = fr_count;
    res.construction_rules   = fr_dfh[23:21];
    res.protocol_id          = fr_dfh[20:16];
    res.first_header_pointer = fr_dfh[15:0];
    res.last_of_frame        = (fr_end != 0) && (p + 1 == fr_end);

    if (fr_pos < POS_MAX) fr_pos = fr_pos + 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // Checking
  // -------------------------------------------------------------------------
  task automatic flag_error(input string msg);
    error_count++;
    // Keep the log short when everything goes wrong at once
    if (error_count <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s = %0h, expected %0h",
                           results_seen, name, got, want));
  endtask

  task automatic check_tag(input usdl_out_t got);
    usdl_out_t want;
    if (tags_due.size() == 0) begin
      flag_error($sformatf("result %0d arrived with nothing pending (byte %02h)",
                           results_seen, got.byte_out));
      return;
    end
    want = tags_due.pop_front();
    compare_field("role",                 got.role,                 want.role);
    compare_field("byte_out",             got.byte_out,             want.byte_out);
    compare_field("status",               got.status,               want.status);
    compare_field("spacecraft_id",        got.spacecraft_id,        want.spacecraft_id);
    compare_field("channel_id",           got.channel_id,           want.channel_id);
    compare_field("map_number",           got.map_number,           want.map_number);
    compare_field("header_flags",         got.header_flags,         want.header_flags);
    compare_field("frame_count",          got.frame_count,          want.frame_count);
    compare_field("construction_rules",   got.construction_rules,   want.construction_rules);
    compare_field("protocol_id",          got.protocol_id,          want.protocol_id);
    compare_field("first_header_pointer", got.first_header_pointer, want.first_header_pointer);
    compare_field("last_of_frame",        got.last_of_frame,        want.last_of_frame);
  endtask

  // -------------------------------------------------------------------------
  // Driver: one byte offered at a time; a new one is loaded only when the
  // current one transfers or none is offered, so valid never drops early.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    usdl_out_t tag;
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      clear_frame_state();
    end else begin
      if (in_valid && in_ready) begin
        tag_byte(in_data, tag);
        tags_due.push_back(tag);
      end
      if (!in_valid || in_ready) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= bytes_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Monitor: random back-pressure, plus a long hold on request so the output
  // queue fills and the input side stalls.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        check_tag(out_data);
        results_seen++;
      end
      if (hold_served != hold_asked) begin
        hold_served <= hold_asked;
        hold_left   <= HOLD_CYCLES;
        out_ready   <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] data, input logic start);
    usdl_in_t item;
    item.data_byte   = data;
    item.frame_start = start;
    bytes_to_send.push_back(item);
  endtask

  // Register writes; the model copy changes with them since no byte is in
  // flight while they happen.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_EXP_VERSION: cfg_m.expected_version = value[3:0];
      CFG_FRAME_LEN:   cfg_m.frame_length     = value;
      CFG_VAR_LEN:     cfg_m.variable_length  = value[0];
      CFG_FEC_PRESENT: cfg_m.fec_present      = value[0];
      CFG_FEC_BYTES:   cfg_m.fec_bytes        = value[7:0];
      CFG_INS_BYTES:   cfg_m.insert_bytes     = value[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [3:0] version, input logic [16:0] flen,
                                input logic var_len, input logic fec_on,
                                input logic [7:0] fec_len, input logic [7:0] ins_len);
    write_reg(CFG_EXP_VERSION, CFG_W'(version));
    write_reg(CFG_FRAME_LEN,   flen);
    write_reg(CFG_VAR_LEN,     CFG_W'(var_len));
    write_reg(CFG_FEC_PRESENT, CFG_W'(fec_on));
    write_reg(CFG_FEC_BYTES,   CFG_W'(fec_len));
    write_reg(CFG_INS_BYTES,   CFG_W'(ins_len));
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Everything sent, every tag back, then a final wait for the pipeline.
  // Sampled on the falling edge so the driver and monitor updates have landed.
  task automatic wait_drained();
    while (bytes_to_send.size() != 0 || in_valid || tags_due.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One frame of random bytes with version, truncation bit and length field
  // forced according to the kind and the current settings.
  task automatic queue_frame(input frame_kind_t kind, input int unsigned len_cap,
                             output int unsigned n_sent);
    int unsigned total, lo, top, n;
    logic [15:0] len_field;
    usdl_in_t    item;
    if (kind == FRM_NOISE) begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++)
        push_byte(8'($urandom), $urandom_range(7) == 0);
      n_sent = n;
      return;
    end

    if (kind == FRM_TRUNC || !cfg_m.variable_length) begin
      total = cfg_m.frame_length;
    end else begin
      // Variable frames: mostly long enough to reach the trailers
      top   = (cfg_m.frame_length < len_cap) ? cfg_m.frame_length : len_cap;
      lo    = ($urandom_range(9) == 0 || top < 12) ? 1 : 12;
      total = $urandom_range(top, lo);
    end

    len_field = 16'(total - 1);
    if (kind == FRM_BAD_LENGTH) begin
      if (!cfg_m.variable_length)
        len_field = len_field ^ 16'($urandom_range(16'hFFFF, 1));
      else if (cfg_m.frame_length <= 17'h0FFFF)
        len_field = 16'($urandom_range(16'hFFFF, cfg_m.frame_length));
    end

    case (kind)
      FRM_CUT:                        n = (total > 1) ? $urandom_range(total - 1, 1) : 1;
      FRM_OVERRUN:                    n = total + $urandom_range(4, 1);
      FRM_BAD_VERSION, FRM_BAD_LENGTH: n = (total < 24) ? total : 24;
      default:                        n = total;
    endcase
    if (n > SEND_MAX) n = SEND_MAX;

    for (int i = 0; i < n; i++) begin
      item.data_byte   = 8'($urandom);
      item.frame_start = (i == 0);
      case (i)
        0: item.data_byte[7:4] = (kind == FRM_BAD_VERSION)
                                 ? cfg_m.expected_version ^ 4'($urandom_range(15, 1))
                                 : cfg_m.expected_version;
        3: item.data_byte[0] = (kind == FRM_TRUNC);
        4: if (kind != FRM_TRUNC) item.data_byte = len_field[15:8];
        5: if (kind != FRM_TRUNC) item.data_byte = len_field[7:0];
        default: ;
      endcase
      bytes_to_send.push_back(item);
    end
    n_sent = n;
  endtask

  // -------------------------------------------------------------------------
  // Test sequence
  // -------------------------------------------------------------------------
  initial begin
    int unsigned queued, n, len_cap, r;
    frame_kind_t kind;

    cfg_m                  = '0;
    cfg_m.expected_version = 4'd12;
    cfg_m.frame_length     = 17'd256;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // --- directed part, reset settings: version 12, fixed 256-byte frames ---
    // stray bytes before any frame start: discarded, status ok
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // wrong version: error shown on the first byte, rest discarded
    push_byte(8'h3A, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    // length field 0x0010 against the fixed 256 setting
    push_byte(8'hC5, 1'b1);
    push_byte(8'h12, 1'b0);
    push_byte(8'h34, 1'b0);
    push_byte(8'h56, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    // truncated header, then data field header with pointer (rules 0)
    push_byte(8'hCF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h12, 1'b0);

    // --- random phases under changing settings ---
    for (int ph = 0; ph < N_PHASES; ph++) begin
      wait_drained();
      len_cap = 64;
      case (ph)
        0: apply_settings(4'd0, 17'd8, 1'b0, 1'b0, 8'd0, 8'd0);
        1: begin
          // widest settings; trailers and insert overlap and eat the payload
          apply_settings(4'd15, 17'd65536, 1'b1, 1'b1, 8'd255, 8'd255);
          len_cap = 200;
        end
        default: begin
          if (ph == 2) begin
            // unused slots must not disturb anything
            write_reg(CFG_SPARE,    CFG_W'($urandom));
            write_reg(CFG_UNMAPPED, CFG_W'($urandom));
          end
          apply_settings(4'($urandom_range(15)),
                         ($urandom_range(3) == 0) ? 17'($urandom_range(300, 65))
                                                  : 17'($urandom_range(64, 8)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(6)),
                         ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(4)));
        end
      endcase

      queued = 0;
      while (queued < PHASE_BYTES) begin
        r = $urandom_range(99);
        if      (r < 55) kind = FRM_GOOD;
        else if (r < 65) kind = FRM_TRUNC;
        else if (r < 72) kind = FRM_BAD_VERSION;
        else if (r < 80) kind = FRM_BAD_LENGTH;
        else if (r < 88) kind = FRM_CUT;
        else if (r < 95) kind = FRM_OVERRUN;
        else             kind = FRM_NOISE;
        queue_frame(kind, len_cap, n);
        queued += n;
      end

      // Hold the output while the sender keeps offering bytes
      if (ph == STALL_PHASE) hold_asked++;
    end

    // --- no idling on either side: a frame, stray bytes past its end,
    // then a fresh frame ---
    wait_drained();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_frame(FRM_GOOD, 64, n);
    for (int i = 0; i < 24; i++) push_byte(8'($urandom), 1'b0);
    queue_frame(FRM_GOOD, 64, n);

    wait_drained();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout: %0d tags still pending", tags_due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
